@@ rtl/sha256_pkg.sv @@
package sha256_pkg;

	typedef enum logic [1:0] {
		SRC_IN,
		SRC_HELD,
		SRC_PAD,
		SRC_ZERO
	} src_sel_t;

	typedef struct packed {
		logic       take;
		logic       ins;
		src_sel_t   src;
		logic [2:0] nbytes;
		logic       write_len;
		logic       load_work;
		logic       round;
		logic [5:0] rnd;
		logic       update;
		logic       last_blk;
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       out_busy;
	} sha_sts_t;

	localparam logic [2:0]  MAX_BYTES = 3'd4;
	localparam logic [31:0] PAD_WORD  = 32'h8000_0000;
	localparam logic [5:0]  LEN_FILL  = 6'd56;
	localparam logic [5:0]  LAST_ROUND = 6'd63;

	localparam logic [31:0] HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [2:0] clamp_count(input logic [2:0] b);
		return (b > MAX_BYTES) ? MAX_BYTES : b;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		unique case (t)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

endpackage

@@ rtl/sha256_dp.sv @@
module sha256_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha256_pkg::sha_cmd_t cmd,
	input  logic [31:0]          message_word,
	input  logic [2:0]           bytes_valid,
	output sha256_pkg::sha_sts_t sts,
	output logic                 dig_valid,
	input  logic                 dig_stall,
	output logic [31:0]          digest_word,
	output logic [2:0]           word_index,
	output logic                 last_word
);
	import sha256_pkg::*;

	logic [31:0] blk_q [16];
	logic [31:0] work_q [8];
	logic [31:0] hash_q [8];
	logic [31:0] dig_q [8];
	logic [31:0] word_q;
	logic [63:0] bit_q;
	logic [5:0]  fill_q;
	logic [2:0]  dcnt_q;
	logic        dvalid_q;

	logic [31:0] src_word;
	logic [31:0] word_nx;
	logic        byte_we [64];
	logic [7:0]  byte_val [64];
	logic [31:0] sched_new;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;
	logic        dig_xfer;

	always_comb begin
		logic [5:0] off;
		unique case (cmd.src)
			SRC_IN:   src_word = message_word;
			SRC_HELD: src_word = word_q;
			SRC_PAD:  src_word = PAD_WORD;
			SRC_ZERO: src_word = '0;
		endcase
		word_nx = src_word << {cmd.nbytes, 3'b000};
		// byte p of the block takes source byte p - fill when that falls inside the insert
		for (int p = 0; p < 64; p++) begin
			off = 6'(p) - fill_q;
			byte_we[p] = cmd.ins && (off < {3'b000, cmd.nbytes});
			byte_val[p] = src_word[{~off[1:0], 3'b000} +: 8];
		end
	end

	always_comb begin
		sched_new = sml_sig1(blk_q[14]) + blk_q[9] + sml_sig0(blk_q[1]) + blk_q[0];
		ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		t1  = work_q[7] + big_sig1(work_q[4]) + ch + round_k(cmd.rnd) + blk_q[0];
		t2  = big_sig0(work_q[0]) + maj;
	end

	// block buffer doubles as the message schedule window during rounds
	always_ff @(posedge clk) begin
		if (cmd.round) begin
			for (int i = 0; i < 15; i++)
				blk_q[i] <= blk_q[i + 1];
			blk_q[15] <= sched_new;
		end else if (cmd.write_len) begin
			blk_q[14] <= bit_q[63:32];
			blk_q[15] <= bit_q[31:0];
		end else begin
			for (int p = 0; p < 64; p++)
				if (byte_we[p])
					blk_q[4'(p >> 2)][8 * (3 - (p & 3)) +: 8] <= byte_val[p];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins)
			word_q <= word_nx;
		if (cmd.load_work) begin
			for (int i = 0; i < 8; i++)
				work_q[i] <= hash_q[i];
		end else if (cmd.round) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
		if (cmd.update && cmd.last_blk) begin
			for (int i = 0; i < 8; i++)
				dig_q[i] <= hash_q[i] + work_q[i];
		end else if (dig_xfer) begin
			for (int i = 0; i < 7; i++)
				dig_q[i] <= dig_q[i + 1];
		end
	end

	assign dig_xfer = dvalid_q && !dig_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				hash_q[i] <= HASH_IV[i];
			bit_q    <= '0;
			fill_q   <= '0;
			dcnt_q   <= '0;
			dvalid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				for (int i = 0; i < 8; i++)
					hash_q[i] <= cmd.last_blk ? HASH_IV[i] : hash_q[i] + work_q[i];
			end
			if (cmd.take)
				bit_q <= bit_q + 64'({clamp_count(bytes_valid), 3'b000});
			else if (cmd.update && cmd.last_blk)
				bit_q <= '0;
			if (cmd.write_len)
				fill_q <= '0;
			else if (cmd.ins)
				fill_q <= fill_q + 6'(cmd.nbytes);
			if (cmd.update && cmd.last_blk) begin
				dvalid_q <= 1'b1;
				dcnt_q   <= '0;
			end else if (dig_xfer) begin
				dcnt_q <= dcnt_q + 3'd1;
				if (dcnt_q == 3'd7)
					dvalid_q <= 1'b0;
			end
		end
	end

	assign sts.fill     = fill_q;
	assign sts.out_busy = dvalid_q;
	assign dig_valid    = dvalid_q;
	assign digest_word  = dig_q[0];
	assign word_index   = dcnt_q;
	assign last_word    = (dcnt_q == 3'd7);

endmodule

@@ rtl/sha256_ctrl.sv @@
module sha256_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 msg_valid,
	output logic                 msg_stall,
	input  logic [2:0]           bytes_valid,
	input  logic                 is_last,
	input  sha256_pkg::sha_sts_t sts,
	output sha256_pkg::sha_cmd_t cmd
);
	import sha256_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_ROUND,
		ST_UPDATE
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] left_q, left_d;
	logic       last_q, last_d;
	logic       pad_q, pad_d;
	logic       fin_q, fin_d;
	logic [5:0] rnd_q, rnd_d;

	logic [6:0] fill7;
	logic [6:0] room;
	logic [6:0] zroom;
	logic [2:0] cnt;
	logic [2:0] avail;
	logic [2:0] n_data;
	logic [2:0] n_zero;
	logic       wrap_data;
	logic       wrap_zero;
	logic       wrap_pad;

	always_comb begin
		fill7     = {1'b0, sts.fill};
		room      = 7'd64 - fill7;
		zroom     = ((sts.fill < LEN_FILL) ? 7'd56 : 7'd64) - fill7;
		cnt       = clamp_count(bytes_valid);
		avail     = (state_q == ST_IDLE) ? cnt : left_q;
		// never cross the block end in one insert; the rest follows after compression
		n_data    = ({4'b0000, avail} > room) ? room[2:0] : avail;
		n_zero    = (zroom > 7'({MAX_BYTES})) ? MAX_BYTES : zroom[2:0];
		wrap_data = (fill7 + {4'b0000, n_data}) == 7'd64;
		wrap_zero = (fill7 + {4'b0000, n_zero}) == 7'd64;
		wrap_pad  = (sts.fill == 6'd63);
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		left_d  = left_q;
		last_d  = last_q;
		pad_d   = pad_q;
		fin_d   = fin_q;
		rnd_d   = rnd_q;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_valid) begin
					cmd.take   = 1'b1;
					cmd.ins    = 1'b1;
					cmd.src    = SRC_IN;
					cmd.nbytes = n_data;
					left_d     = cnt - n_data;
					last_d     = is_last;
					pad_d      = 1'b0;
					fin_d      = 1'b0;
					if (wrap_data) begin
						cmd.load_work = 1'b1;
						state_d       = ST_ROUND;
					end else if (is_last) begin
						state_d = ST_FEED;
					end
				end
			end
			ST_FEED: begin
				priority if (left_q != 3'd0) begin
					cmd.ins    = 1'b1;
					cmd.src    = SRC_HELD;
					cmd.nbytes = n_data;
					left_d     = left_q - n_data;
					if (wrap_data) begin
						cmd.load_work = 1'b1;
						state_d       = ST_ROUND;
					end else if (!last_q) begin
						state_d = ST_IDLE;
					end
				end else if (!last_q) begin
					state_d = ST_IDLE;
				end else if (!pad_q) begin
					cmd.ins    = 1'b1;
					cmd.src    = SRC_PAD;
					cmd.nbytes = 3'd1;
					pad_d      = 1'b1;
					if (wrap_pad) begin
						cmd.load_work = 1'b1;
						state_d       = ST_ROUND;
					end
				end else if (sts.fill != LEN_FILL) begin
					cmd.ins    = 1'b1;
					cmd.src    = SRC_ZERO;
					cmd.nbytes = n_zero;
					if (wrap_zero) begin
						cmd.load_work = 1'b1;
						state_d       = ST_ROUND;
					end
				end else begin
					cmd.write_len = 1'b1;
					cmd.load_work = 1'b1;
					fin_d         = 1'b1;
					state_d       = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				cmd.rnd   = rnd_q;
				rnd_d     = rnd_q + 6'd1;
				if (rnd_q == LAST_ROUND)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				// hold the final update until the digest buffer has drained
				if (!(fin_q && sts.out_busy)) begin
					cmd.update   = 1'b1;
					cmd.last_blk = fin_q;
					state_d      = fin_q ? ST_IDLE : ST_FEED;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
			last_q  <= 1'b0;
			pad_q   <= 1'b0;
			fin_q   <= 1'b0;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			left_q  <= left_d;
			last_q  <= last_d;
			pad_q   <= pad_d;
			fin_q   <= fin_d;
			rnd_q   <= rnd_d;
		end
	end

	assign msg_stall = (state_q != ST_IDLE);

	a_digest_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && cmd.last_blk) |-> !sts.out_busy)
		else $error("digest buffer overwritten before drained");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == LAST_ROUND) |=> (state_q == ST_UPDATE))
		else $error("compression did not end after the last round");

	a_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_work |=> (state_q == ST_ROUND && rnd_q == 6'd0))
		else $error("compression did not start at round zero");

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_len |-> (sts.fill == LEN_FILL && pad_q))
		else $error("length written at wrong fill position");

endmodule

@@ rtl/sha256_message_hasher.sv @@
// SHA-256 of a byte message. Send the message as big-endian words with up to four
// valid bytes each (first byte in bits 31..24); mark the final word with is_last.
// Short words are allowed anywhere and later bytes simply follow them. A word that
// fits in the current 64-byte block is accepted without a stall; a full block then
// holds input off through 64 rounds on the single round unit, the hash update
// and the placing of any held bytes. The end of a message pads up to four bytes
// a cycle and compresses one or two more blocks. The eight digest words leave
// from their own buffer, word 0 first, so the next message can start while they
// wait; a second digest is held back until that buffer has drained. The hash
// state returns to the standard initial value after every message.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [31:0] message_word,
	input  logic [2:0]  bytes_valid,
	input  logic        is_last,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha256_pkg::*;

	sha_cmd_t cmd;
	sha_sts_t sts;

	sha256_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg_valid   (msg_valid),
		.msg_stall   (msg_stall),
		.bytes_valid (bytes_valid),
		.is_last     (is_last),
		.sts         (sts),
		.cmd         (cmd)
	);

	sha256_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.message_word (message_word),
		.bytes_valid  (bytes_valid),
		.sts          (sts),
		.dig_valid    (dig_valid),
		.dig_stall    (dig_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

endmodule
